FILE: rtl/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  // Default table capacity
  localparam int DEPTH_DEF = 64;

  // Iteration counts of the shared arithmetic
  localparam int STEP_W     = 6;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 33;
  localparam int SQ_STEPS   = 4;
  localparam int MUL_STEPS  = 3;
  localparam int NUM_PTS    = 6;

  // Opcodes
  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_POINTS  = 2'd0;
  localparam logic [1:0] ST_SPAWNED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SEG_LEN = 1'b0;
  localparam logic CFG_SPEED   = 1'b1;

  localparam logic [30:0] SEG_LEN_RST = 31'd65536;
  localparam logic [30:0] SPEED_RST   = 31'd65536;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              take;
    logic              spawn;
    logic              rd;
    logic              ld;
    logic              sq;
    logic              rt_init;
    logic              rt;
    logic              mul;
    logic              div;
    logic              div_last;
    logic              fill;
    logic [STEP_W-1:0] step;
    logic [2:0]        pt;
  } stt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic live_zero;
    logic acc_zero;
    logic last_entry;
  } stt_stat_t;

endpackage

`default_nettype wire

FILE: rtl/segment_tracer_table_top.sv
// Segment tracer table: a table of moving line segments in Q16.16.
// Input channel (in_valid / in_stall): in_opcode spawn stores a tracer in the
// next free slot and answers with one status transfer (spawned or dropped
// when full); tick advances every live tracer by travel_speed * in_elapsed
// and answers with one segment transfer per live slot, out_last on the final
// one. A tick on an empty table gives no transfer.
// Output channel (out_valid / out_stall): one result register; a stalled
// result is held unchanged and the block waits on it. One item is in work
// at a time: in_stall stays high until its last result has been taken.
// Sequence: a spawn writes its row and its result register together and
// then offers the result. A tick works through each live slot in turn and
// offers its segment: the shared root unit takes 33 steps and the shared
// divider 33 steps for each of the six coordinates, each after a split
// multiply. A slot with coincident endpoints skips the root and the divider.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 segment
// length, index 1 travel speed; write only while idle.
// Reset (rst_n, synchronous): empties the table and loads both registers
// with 1.0; slot contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module segment_tracer_table_top
  import stt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [31:0] in_src_x,
  input  logic signed [31:0] in_src_y,
  input  logic signed [31:0] in_src_z,
  input  logic signed [31:0] in_dst_x,
  input  logic signed [31:0] in_dst_y,
  input  logic signed [31:0] in_dst_z,
  input  logic [15:0]        in_elapsed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [5:0]         out_entry_index,
  output logic signed [31:0] out_start_x,
  output logic signed [31:0] out_start_y,
  output logic signed [31:0] out_start_z,
  output logic signed [31:0] out_end_x,
  output logic signed [31:0] out_end_y,
  output logic signed [31:0] out_end_z,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  stt_cmd_t         cmd;
  stt_stat_t        stat;
  logic [IDX_W-1:0] idx;

  // Accept configuration writes at any time
  assign cfg_ready = 1'b1;

  stt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .idx       (idx)
  );

  stt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .idx             (idx),
    .stat            (stat),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_src_x        (in_src_x),
    .in_src_y        (in_src_y),
    .in_src_z        (in_src_z),
    .in_dst_x        (in_dst_x),
    .in_dst_y        (in_dst_y),
    .in_dst_z        (in_dst_z),
    .in_elapsed      (in_elapsed),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_start_x     (out_start_x),
    .out_start_y     (out_start_y),
    .out_start_z     (out_start_z),
    .out_end_x       (out_end_x),
    .out_end_y       (out_end_y),
    .out_end_z       (out_end_z),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

FILE: rtl/stt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_ctrl
  import stt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_opcode,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  stt_stat_t        stat,
  output stt_cmd_t         cmd,
  output logic [IDX_W-1:0] idx
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SPAWN = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_LD    = 10'b0000001000,
    S_SQ    = 10'b0000010000,
    S_RTI   = 10'b0000100000,
    S_RT    = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [2:0]        pt_r, pt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // Sequence one item through the datapath
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    pt_nxt       = pt_r;
    idx_nxt      = idx_r;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    cmd          = '0;
    cmd.step     = step_r;
    cmd.pt       = pt_r;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_opcode == OP_SPAWN) begin
            state_nxt = S_SPAWN;
          end else if (!stat.live_zero) begin
            idx_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_SPAWN: begin
        cmd.spawn = 1'b1;
        state_nxt = S_OUT;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        cmd.ld    = 1'b1;
        step_nxt  = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq   = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQ_STEPS - 1)) begin
          state_nxt = S_RTI;
        end
      end
      S_RTI: begin
        cmd.rt_init = 1'b1;
        step_nxt    = '0;
        if (stat.acc_zero) begin
          cmd.fill  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RT;
        end
      end
      S_RT: begin
        cmd.rt = 1'b1;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          step_nxt  = '0;
          pt_nxt    = '0;
          state_nxt = S_MUL;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          cmd.div_last = 1'b1;
          step_nxt     = '0;
          if (pt_r == 3'(NUM_PTS - 1)) begin
            state_nxt = S_OUT;
          end else begin
            pt_nxt    = pt_r + 3'd1;
            state_nxt = S_MUL;
          end
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (stat.last_entry) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      pt_r    <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pt_r    <= pt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign idx = idx_r;

endmodule

`default_nettype wire

FILE: rtl/stt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_datapath
  import stt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stt_cmd_t           cmd,
  input  logic [IDX_W-1:0]   idx,
  output stt_stat_t          stat,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic signed [31:0] in_src_x,
  input  logic signed [31:0] in_src_y,
  input  logic signed [31:0] in_src_z,
  input  logic signed [31:0] in_dst_x,
  input  logic signed [31:0] in_dst_y,
  input  logic signed [31:0] in_dst_z,
  input  logic [15:0]        in_elapsed,
  output logic [1:0]         out_status,
  output logic [5:0]         out_entry_index,
  output logic signed [31:0] out_start_x,
  output logic signed [31:0] out_start_y,
  output logic signed [31:0] out_start_z,
  output logic signed [31:0] out_end_x,
  output logic signed [31:0] out_end_y,
  output logic signed [31:0] out_end_z,
  output logic               out_last
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Configuration
  logic [30:0] seg_len_r;
  logic [30:0] speed_r;

  // Table storage
  logic [95:0] src_mem [TABLE_DEPTH];
  logic [95:0] dst_mem [TABLE_DEPTH];
  logic [31:0] prog_mem [TABLE_DEPTH];
  logic [CNT_W-1:0] live_cnt_r;

  // Latched input
  logic [95:0] in_src_r, in_dst_r;
  logic [30:0] inc_r;

  // Entry in work
  logic [95:0] src_q_r, dst_q_r;
  logic [31:0] prog_q_r;
  logic [32:0] mag_r [3];
  logic [2:0]  neg_r;
  logic signed [32:0] ps_r, pe_r;
  logic [65:0] prod_r, acc_r;
  logic [65:0] rad_r;
  logic [34:0] rem_r;
  logic [32:0] root_r;
  logic [49:0] pp_lo_r;
  logic [48:0] pp_hi_r;
  logic [32:0] rem_d_r, nq_r;

  // Result register
  logic [1:0]  status_r;
  logic [5:0]  entry_r;
  logic [31:0] pts_r [NUM_PTS];
  logic        last_r;

  function automatic logic [32:0] clamp_t(logic signed [32:0] x, logic [32:0] len);
    logic [32:0] r;
    if (x <= 33'sd0) begin
      r = '0;
    end else if ($signed({1'b0, len}) < {x[32], x}) begin
      r = len;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // Progress update and per-axis offsets
  logic signed [32:0] p_sum;
  logic [31:0]        p_sat;
  logic signed [32:0] dl [3];

  always_comb begin
    p_sum = $signed({prog_q_r[31], prog_q_r}) + $signed({2'b00, inc_r});
    p_sat = (p_sum > 33'sh07FFFFFFF) ? 32'h7FFFFFFF : p_sum[31:0];
    for (int a = 0; a < 3; a++) begin
      dl[a] = $signed({dst_q_r[95 - 32*a], dst_q_r[95 - 32*a -: 32]})
            - $signed({src_q_r[95 - 32*a], src_q_r[95 - 32*a -: 32]});
    end
  end

  // Square of one axis
  logic [1:0]  sq_axis;
  logic [32:0] sq_mag;
  assign sq_axis = (cmd.step[1:0] == 2'd3) ? 2'd2 : cmd.step[1:0];
  assign sq_mag  = mag_r[sq_axis];

  // Root step: two radicand bits in, one root bit out
  logic [36:0] rt_remx, rt_trial;
  logic        rt_ge;
  assign rt_remx  = {rem_r, rad_r[65:64]};
  assign rt_trial = {2'b00, root_r, 2'b01};
  assign rt_ge    = rt_remx >= rt_trial;

  // Operand selection for the point in work
  logic [1:0]  pt_axis;
  logic [32:0] pt_t;
  logic [32:0] pt_mag;
  logic [31:0] pt_src;
  logic [65:0] pt_num;
  assign pt_axis = (cmd.pt >= 3'd3) ? 2'(cmd.pt - 3'd3) : cmd.pt[1:0];
  assign pt_t    = clamp_t((cmd.pt < 3'd3) ? ps_r : pe_r, root_r);
  assign pt_mag  = mag_r[pt_axis];
  assign pt_src  = src_q_r[95 - 32*pt_axis -: 32];
  assign pt_num  = 66'(pp_lo_r) + {pp_hi_r, 17'b0};

  // Division step: one quotient bit
  logic [33:0] dv_remx;
  logic        dv_ge;
  logic [32:0] dv_q;
  logic [33:0] dv_off;
  logic [31:0] dv_point;
  assign dv_remx  = {rem_d_r, nq_r[32]};
  assign dv_ge    = dv_remx >= {1'b0, root_r};
  assign dv_q     = {nq_r[31:0], dv_ge};
  assign dv_off   = neg_r[pt_axis] ? -{1'b0, dv_q} : {1'b0, dv_q};
  assign dv_point = 32'({{2{pt_src[31]}}, pt_src} + dv_off);

  // Configuration registers and live count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r  <= SEG_LEN_RST;
      speed_r    <= SPEED_RST;
      live_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEG_LEN: seg_len_r <= cfg_data;
          CFG_SPEED:   speed_r   <= cfg_data;
          default:     ;
        endcase
      end
      if (cmd.spawn && (live_cnt_r < CNT_W'(TABLE_DEPTH))) begin
        live_cnt_r <= live_cnt_r + CNT_W'(1);
      end
    end
  end

  // Table memories: spawn fills a free row; tick reads one, writes progress back
  always_ff @(posedge clk) begin
    if (cmd.spawn && (live_cnt_r < CNT_W'(TABLE_DEPTH))) begin
      src_mem[live_cnt_r[IDX_W-1:0]]  <= in_src_r;
      dst_mem[live_cnt_r[IDX_W-1:0]]  <= in_dst_r;
      prog_mem[live_cnt_r[IDX_W-1:0]] <= -{1'b0, seg_len_r};
    end else if (cmd.ld) begin
      prog_mem[idx] <= p_sat;
    end
    if (cmd.rd) begin
      src_q_r  <= src_mem[idx];
      dst_q_r  <= dst_mem[idx];
      prog_q_r <= prog_mem[idx];
    end
  end

  // Arithmetic datapath
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_src_r <= {in_src_x, in_src_y, in_src_z};
      in_dst_r <= {in_dst_x, in_dst_y, in_dst_z};
      inc_r    <= 31'((47'(speed_r) * 47'(in_elapsed)) >> 16);
    end
    if (cmd.ld) begin
      for (int a = 0; a < 3; a++) begin
        neg_r[a] <= dl[a][32];
        mag_r[a] <= dl[a][32] ? 33'(-dl[a]) : 33'(dl[a]);
      end
      pe_r <= {p_sat[31], p_sat};
      ps_r <= $signed({p_sat[31], p_sat}) + $signed({2'b00, seg_len_r});
    end
    if (cmd.sq) begin
      prod_r <= 66'(sq_mag) * 66'(sq_mag);
      acc_r  <= (cmd.step == '0) ? '0 : acc_r + prod_r;
    end
    if (cmd.rt_init) begin
      rad_r  <= acc_r;
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.rt) begin
      rem_r  <= rt_ge ? 35'(rt_remx - rt_trial) : rt_remx[34:0];
      root_r <= {root_r[31:0], rt_ge};
      rad_r  <= {rad_r[63:0], 2'b00};
    end
    if (cmd.mul) begin
      case (cmd.step[1:0])
        2'd0: pp_lo_r <= 50'(pt_mag) * 50'(pt_t[16:0]);
        2'd1: pp_hi_r <= 49'(pt_mag) * 49'(pt_t[32:17]);
        default: begin
          rem_d_r <= pt_num[65:33];
          nq_r    <= pt_num[32:0];
        end
      endcase
    end
    if (cmd.div) begin
      rem_d_r <= dv_ge ? 33'(dv_remx - {1'b0, root_r}) : dv_remx[32:0];
      nq_r    <= dv_q;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.spawn) begin
      for (int k = 0; k < NUM_PTS; k++) pts_r[k] <= '0;
      last_r <= 1'b1;
      if (live_cnt_r < CNT_W'(TABLE_DEPTH)) begin
        status_r <= ST_SPAWNED;
        entry_r  <= 6'(live_cnt_r);
      end else begin
        status_r <= ST_DROPPED;
        entry_r  <= '0;
      end
    end
    if (cmd.ld) begin
      status_r <= ST_POINTS;
      entry_r  <= 6'(idx);
      last_r   <= (CNT_W'(idx) + CNT_W'(1)) == live_cnt_r;
    end
    if (cmd.fill) begin
      for (int k = 0; k < NUM_PTS; k++) begin
        pts_r[k] <= src_q_r[95 - 32*(k % 3) -: 32];
      end
    end
    if (cmd.div_last) begin
      pts_r[cmd.pt] <= dv_point;
    end
  end

  assign stat.live_zero  = live_cnt_r == '0;
  assign stat.acc_zero   = acc_r == '0;
  assign stat.last_entry = last_r;

  assign out_status      = status_r;
  assign out_entry_index = entry_r;
  assign out_start_x     = pts_r[0];
  assign out_start_y     = pts_r[1];
  assign out_start_z     = pts_r[2];
  assign out_end_x       = pts_r[3];
  assign out_end_y       = pts_r[4];
  assign out_end_z       = pts_r[5];
  assign out_last        = last_r;

endmodule

`default_nettype wire
